### sv/cfwt_pkg.sv
package cfwt_pkg;

	localparam int DEPTH = 16;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int WORD_W = 32;
	localparam int QS_W = 5;
	localparam int KIND_W = 2;
	localparam int ST_W = 2;
	localparam int OBUF_DEPTH = 2;

	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TRAVERSE = 2'd2;

	localparam logic [ST_W-1:0] ST_OK = 2'd0;
	localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd1;
	localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd2;

	localparam logic [QS_W-1:0] QS_RESET = 5'd16;

	typedef struct packed {
		logic we;
		logic re;
		logic [PTR_W-1:0] addr;
		logic [WORD_W-1:0] wdata;
	} mem_cmd_t;

	typedef struct packed {
		logic [ST_W-1:0] status;
		logic last;
		logic from_mem;
	} res_t;

	typedef struct packed {
		logic [ST_W-1:0] status;
		logic [WORD_W-1:0] data;
		logic last;
	} beat_t;

	function automatic logic [CNT_W-1:0] cap_of(input logic [QS_W-1:0] qs);
		logic [CNT_W-1:0] c;
		if (qs == '0) begin
			c = CNT_W'(1);
		end else if (int'(qs) > DEPTH) begin
			c = CNT_W'(DEPTH);
		end else begin
			c = CNT_W'(qs);
		end
		return c;
	endfunction

	function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] idx,
			input logic [CNT_W-1:0] cap);
		logic [PTR_W:0] nxt;
		logic [PTR_W-1:0] r;
		nxt = {1'b0, idx} + (PTR_W + 1)'(1);
		if (int'(nxt) >= int'(cap)) begin
			r = '0;
		end else begin
			r = nxt[PTR_W-1:0];
		end
		return r;
	endfunction

endpackage

### sv/cfwt_ram.sv
module cfwt_ram #(
	parameter int DATA_W = 32,
	parameter int ADDR_W = 4
) (
	input logic clk,
	input logic we,
	input logic re,
	input logic [ADDR_W-1:0] addr,
	input logic [DATA_W-1:0] wdata,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

### sv/cfwt_obuf.sv
module cfwt_obuf (
	input logic clk,
	input logic arst_n,
	input logic push,
	input cfwt_pkg::beat_t push_beat,
	output logic valid,
	input logic ready,
	output cfwt_pkg::beat_t beat,
	output logic [1:0] cnt
);

	cfwt_pkg::beat_t ent_q [cfwt_pkg::OBUF_DEPTH];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] cnt_q;
	logic pop;

	assign valid = (cnt_q != 2'd0);
	assign beat = ent_q[rd_ptr_q];
	assign cnt = cnt_q;
	assign pop = valid & ready;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### sv/cfwt_ctrl.sv
module cfwt_ctrl (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [cfwt_pkg::QS_W-1:0] cfg_wdata,
	input logic in_valid,
	output logic in_ready,
	input logic [cfwt_pkg::KIND_W-1:0] kind,
	input logic [cfwt_pkg::WORD_W-1:0] data_in,
	input logic room,
	output cfwt_pkg::mem_cmd_t cmd,
	output logic issue,
	output cfwt_pkg::res_t res
);

	logic [cfwt_pkg::QS_W-1:0] qsize_q;
	logic [cfwt_pkg::PTR_W-1:0] head_q;
	logic [cfwt_pkg::PTR_W-1:0] tail_q;
	logic [cfwt_pkg::CNT_W-1:0] count_q;
	logic busy_q;
	logic [cfwt_pkg::PTR_W-1:0] idx_q;
	logic [cfwt_pkg::CNT_W-1:0] rem_q;

	logic [cfwt_pkg::PTR_W-1:0] head_d;
	logic [cfwt_pkg::PTR_W-1:0] tail_d;
	logic [cfwt_pkg::CNT_W-1:0] count_d;
	logic busy_d;
	logic [cfwt_pkg::PTR_W-1:0] idx_d;
	logic [cfwt_pkg::CNT_W-1:0] rem_d;
	logic [cfwt_pkg::CNT_W-1:0] cap;
	logic accept;

	assign cap = cfwt_pkg::cap_of(qsize_q);
	assign in_ready = ~busy_q & room;
	assign accept = in_valid & in_ready;

	always_comb begin
		cmd = '0;
		cmd.wdata = data_in;
		issue = 1'b0;
		res = '0;
		head_d = head_q;
		tail_d = tail_q;
		count_d = count_q;
		busy_d = busy_q;
		idx_d = idx_q;
		rem_d = rem_q;
		if (busy_q) begin
			if (room) begin
				// traverse walk, one entry per beat
				cmd.re = 1'b1;
				cmd.addr = idx_q;
				issue = 1'b1;
				res.status = cfwt_pkg::ST_OK;
				res.from_mem = 1'b1;
				res.last = (rem_q == cfwt_pkg::CNT_W'(1));
				idx_d = cfwt_pkg::advance(idx_q, cap);
				rem_d = rem_q - cfwt_pkg::CNT_W'(1);
				busy_d = (rem_q != cfwt_pkg::CNT_W'(1));
			end
		end else if (accept) begin
			res.last = 1'b1;
			case (kind)
				cfwt_pkg::KIND_INSERT: begin
					issue = 1'b1;
					if (count_q == cap) begin
						res.status = cfwt_pkg::ST_OVERFLOW;
					end else begin
						res.status = cfwt_pkg::ST_OK;
						cmd.we = 1'b1;
						cmd.addr = tail_q;
						tail_d = cfwt_pkg::advance(tail_q, cap);
						count_d = count_q + cfwt_pkg::CNT_W'(1);
					end
				end
				cfwt_pkg::KIND_DELETE: begin
					issue = 1'b1;
					if (count_q == '0) begin
						res.status = cfwt_pkg::ST_UNDERFLOW;
					end else begin
						res.status = cfwt_pkg::ST_OK;
						res.from_mem = 1'b1;
						cmd.re = 1'b1;
						cmd.addr = head_q;
						count_d = count_q - cfwt_pkg::CNT_W'(1);
						if (count_q == cfwt_pkg::CNT_W'(1)) begin
							head_d = '0;
							tail_d = '0;
						end else begin
							head_d = cfwt_pkg::advance(head_q, cap);
						end
					end
				end
				cfwt_pkg::KIND_TRAVERSE: begin
					issue = 1'b1;
					if (count_q == '0) begin
						res.status = cfwt_pkg::ST_UNDERFLOW;
					end else begin
						res.status = cfwt_pkg::ST_OK;
						res.from_mem = 1'b1;
						res.last = (count_q == cfwt_pkg::CNT_W'(1));
						cmd.re = 1'b1;
						cmd.addr = head_q;
						idx_d = cfwt_pkg::advance(head_q, cap);
						rem_d = count_q - cfwt_pkg::CNT_W'(1);
						busy_d = (count_q != cfwt_pkg::CNT_W'(1));
					end
				end
				default: begin
					res.last = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qsize_q <= cfwt_pkg::QS_RESET;
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
			busy_q <= 1'b0;
			idx_q <= '0;
			rem_q <= '0;
		end else if (cfg_we) begin
			qsize_q <= cfg_wdata;
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
			busy_q <= 1'b0;
		end else begin
			head_q <= head_d;
			tail_q <= tail_d;
			count_q <= count_d;
			busy_q <= busy_d;
			idx_q <= idx_d;
			rem_q <= rem_d;
		end
	end

endmodule

### sv/circular_fifo_with_traverse_top.sv
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tuser: kind, tdata: data_in
// m_axis    out  m_axis_tvalid/m_axis_tready   tuser: status, tdata: data_out, tlast: last
// cfg       in   cfg_we                         cfg_wdata: queue_size
//
// insert and delete each issue one result beat and a traverse one read beat per stored entry
// (the ram read is registered); the output buffer check can hold back issues
// even with m_axis always ready
// a result passes through the res_s1 register and the output buffer on its way to m_axis
// reset empties the queue and sets queue_size to 16; no clearing pass is needed
// a stalled m_axis fills a two-beat output buffer, after which s_axis and any walk pause
module circular_fifo_with_traverse_top (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [4:0] cfg_wdata,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [7:0] s_axis_tuser, // kind [1:0]
	input logic [31:0] s_axis_tdata, // data_in [31:0]
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [7:0] m_axis_tuser, // status [1:0]
	output logic [31:0] m_axis_tdata, // data_out [31:0]
	output logic m_axis_tlast
);

	cfwt_pkg::mem_cmd_t cmd;
	cfwt_pkg::res_t res;
	cfwt_pkg::res_t res_s1;
	cfwt_pkg::beat_t push_beat;
	cfwt_pkg::beat_t out_beat;
	logic issue;
	logic v_s1;
	logic room;
	logic [1:0] obuf_cnt;
	logic [cfwt_pkg::WORD_W-1:0] rdata;

	// leave a slot for the beat already in flight
	assign room = (obuf_cnt == 2'd0) | ((obuf_cnt == 2'd1) & ~v_s1);

	cfwt_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.kind(s_axis_tuser[cfwt_pkg::KIND_W-1:0]),
		.data_in(s_axis_tdata),
		.room(room),
		.cmd(cmd),
		.issue(issue),
		.res(res)
	);

	cfwt_ram #(
		.DATA_W(cfwt_pkg::WORD_W),
		.ADDR_W(cfwt_pkg::PTR_W)
	) u_ram (
		.clk(clk),
		.we(cmd.we),
		.re(cmd.re),
		.addr(cmd.addr),
		.wdata(cmd.wdata),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		res_s1 <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= issue;
		end
	end

	always_comb begin
		push_beat.status = res_s1.status;
		push_beat.last = res_s1.last;
		push_beat.data = res_s1.from_mem ? rdata : '0;
	end

	cfwt_obuf u_obuf (
		.clk(clk),
		.arst_n(arst_n),
		.push(v_s1),
		.push_beat(push_beat),
		.valid(m_axis_tvalid),
		.ready(m_axis_tready),
		.beat(out_beat),
		.cnt(obuf_cnt)
	);

	assign m_axis_tuser = {6'd0, out_beat.status};
	assign m_axis_tdata = out_beat.data;
	assign m_axis_tlast = out_beat.last;

endmodule
